// ===== src/ecr_pkg.sv =====
package ecr_pkg;

  // widths of the fixed-point datapath (all magnitudes, sign kept apart)
  localparam int MAG_W  = 33;              // |dv|, |d|
  localparam int PRD_W  = 2 * MAG_W;       // one 33x33 product
  localparam int DOT_W  = PRD_W + 1;       // sum of two products
  localparam int MUL_W  = 17;              // ma+mb and 2*mb
  localparam int BAS_W  = DOT_W + MUL_W;   // base and denominator
  localparam int NUM_W  = BAS_W + MAG_W;   // dividend
  localparam int QUO_W  = 41;              // quotient bits kept, cap is 2^40
  localparam int CMP_W  = BAS_W + QUO_W;   // divider compare width
  localparam int DIV_LAT = QUO_W + 1;      // divider register stages

  localparam logic [QUO_W-1:0] Q_CAP = {1'b1, {(QUO_W-1){1'b0}}};

  typedef struct packed {
    logic             vld;
    logic [NUM_W-1:0] num;
    logic [BAS_W-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic             vld;
    logic [QUO_W-1:0] quo;
  } div_rsp_t;

  typedef struct packed {
    logic        vld;
    logic [31:0] va_x;
    logic [31:0] va_y;
    logic        appr;
    logic        coll;
    logic        coin;
    logic        use_q;
    logic        qneg_x;
    logic        qneg_y;
  } side_t;

endpackage

// ===== src/ecr_div.sv =====
module ecr_div import ecr_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     en,
  input  div_req_t req,
  output div_rsp_t rsp
);

  logic [NUM_W-1:0] rem_r [0:QUO_W-1];
  logic [BAS_W-1:0] den_r [0:QUO_W-1];
  logic [QUO_W-1:0] quo_r [0:QUO_W];
  logic             ovf_r [0:QUO_W];
  logic             vld_r [0:QUO_W];

  // quotient of 2^41 or more is capped anyway, so only the low bits are resolved
  always_ff @(posedge clk) begin
    if (en) begin
      rem_r[0] <= req.num;
      den_r[0] <= req.den;
      quo_r[0] <= '0;
      ovf_r[0] <= CMP_W'(req.num) >= (CMP_W'(req.den) << QUO_W);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r[0] <= 1'b0;
    end else if (en) begin
      vld_r[0] <= req.vld;
    end
  end

  for (genvar k = 1; k <= QUO_W; k++) begin : g_stage
    localparam int B = QUO_W - k;
    logic [CMP_W-1:0] sh;
    logic             take;

    assign sh   = CMP_W'(den_r[k-1]) << B;
    assign take = CMP_W'(rem_r[k-1]) >= sh;

    always_ff @(posedge clk) begin
      if (en) begin
        quo_r[k] <= quo_r[k-1] | (QUO_W'(take) << B);
        ovf_r[k] <= ovf_r[k-1];
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[k] <= 1'b0;
      end else if (en) begin
        vld_r[k] <= vld_r[k-1];
      end
    end

    if (k < QUO_W) begin : g_carry
      always_ff @(posedge clk) begin
        if (en) begin
          rem_r[k] <= take ? NUM_W'(CMP_W'(rem_r[k-1]) - sh) : rem_r[k-1];
          den_r[k] <= den_r[k-1];
        end
      end
    end
  end

  assign rsp.vld = vld_r[QUO_W];
  assign rsp.quo = (ovf_r[QUO_W] || quo_r[QUO_W] > Q_CAP) ? Q_CAP : quo_r[QUO_W];

endmodule

// ===== src/elastic_collision_response_2d_top.sv =====
// Elastic response of particle a to particle b, Q16.16 in and out. Fully pipelined:
// one pair per cycle while the output does not stall (8 datapath stages, a 42-stage
// restoring divider: operand stage, then one quotient bit per stage; one output
// stage). A stalled output freezes the whole pipeline, nothing is lost or repeated.
// The correction term is capped at 2^40 before it is applied to the velocity.
module elastic_collision_response_2d_top import ecr_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [15:0] in_mass_a,
  input  logic [15:0] in_mass_b,
  input  logic [31:0] in_vel_a_x,
  input  logic [31:0] in_vel_a_y,
  input  logic [31:0] in_vel_b_x,
  input  logic [31:0] in_vel_b_y,
  input  logic [31:0] in_pos_a_x,
  input  logic [31:0] in_pos_a_y,
  input  logic [31:0] in_pos_b_x,
  input  logic [31:0] in_pos_b_y,
  input  logic [30:0] in_radius_a,
  input  logic [30:0] in_radius_b,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_approaching,
  output logic        out_colliding,
  output logic [31:0] out_new_vel_x,
  output logic [31:0] out_new_vel_y,
  output logic        out_coincident,
  output logic        out_saturated
);

  logic en;
  logic [7:0] vld_r;
  logic out_valid_r;

  assign en       = !out_valid_r || out_ready;
  assign in_ready = en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[6:0], in_valid};
    end
  end

  // stage 1: differences and sums
  logic [MAG_W-1:0] dx_r, dy_r, dvx_r, dvy_r;
  logic [31:0]      rsum_r;
  logic [MUL_W-1:0] msum_r, mb2_r;
  logic [31:0]      vax1_r, vay1_r;

  always_ff @(posedge clk) begin
    if (en) begin
      dx_r   <= {in_pos_a_x[31], in_pos_a_x} - {in_pos_b_x[31], in_pos_b_x};
      dy_r   <= {in_pos_a_y[31], in_pos_a_y} - {in_pos_b_y[31], in_pos_b_y};
      dvx_r  <= {in_vel_a_x[31], in_vel_a_x} - {in_vel_b_x[31], in_vel_b_x};
      dvy_r  <= {in_vel_a_y[31], in_vel_a_y} - {in_vel_b_y[31], in_vel_b_y};
      rsum_r <= {1'b0, in_radius_a} + {1'b0, in_radius_b};
      msum_r <= {1'b0, in_mass_a} + {1'b0, in_mass_b};
      mb2_r  <= {in_mass_b, 1'b0};
      vax1_r <= in_vel_a_x;
      vay1_r <= in_vel_a_y;
    end
  end

  // stage 2: magnitudes and signs
  logic [MAG_W-1:0] adx2_r, ady2_r, advx2_r, advy2_r;
  logic             nx0_2_r, ny0_2_r, dxn2_r, dyn2_r, coin2_r;
  logic [31:0]      rsum2_r, vax2_r, vay2_r;
  logic [MUL_W-1:0] msum2_r, mb2_2_r;

  always_ff @(posedge clk) begin
    if (en) begin
      adx2_r  <= dx_r[MAG_W-1]  ? ~dx_r + 1'b1  : dx_r;
      ady2_r  <= dy_r[MAG_W-1]  ? ~dy_r + 1'b1  : dy_r;
      advx2_r <= dvx_r[MAG_W-1] ? ~dvx_r + 1'b1 : dvx_r;
      advy2_r <= dvy_r[MAG_W-1] ? ~dvy_r + 1'b1 : dvy_r;
      nx0_2_r <= dvx_r[MAG_W-1] ^ dx_r[MAG_W-1];
      ny0_2_r <= dvy_r[MAG_W-1] ^ dy_r[MAG_W-1];
      dxn2_r  <= dx_r[MAG_W-1];
      dyn2_r  <= dy_r[MAG_W-1];
      coin2_r <= (dx_r == '0) && (dy_r == '0);
      rsum2_r <= rsum_r;
      msum2_r <= msum_r;
      mb2_2_r <= mb2_r;
      vax2_r  <= vax1_r;
      vay2_r  <= vay1_r;
    end
  end

  // stage 3: products
  logic [PRD_W-1:0] px_r, py_r, ax2_r, ay2_r;
  logic [63:0]      rs2_r;
  logic             nx0_3_r, ny0_3_r, dxn3_r, dyn3_r, coin3_r;
  logic [MAG_W-1:0] adx3_r, ady3_r;
  logic [MUL_W-1:0] msum3_r, mb2_3_r;
  logic [31:0]      vax3_r, vay3_r;

  always_ff @(posedge clk) begin
    if (en) begin
      px_r    <= PRD_W'(advx2_r) * PRD_W'(adx2_r);
      py_r    <= PRD_W'(advy2_r) * PRD_W'(ady2_r);
      ax2_r   <= PRD_W'(adx2_r) * PRD_W'(adx2_r);
      ay2_r   <= PRD_W'(ady2_r) * PRD_W'(ady2_r);
      rs2_r   <= 64'(rsum2_r) * 64'(rsum2_r);
      nx0_3_r <= nx0_2_r;
      ny0_3_r <= ny0_2_r;
      dxn3_r  <= dxn2_r;
      dyn3_r  <= dyn2_r;
      coin3_r <= coin2_r;
      adx3_r  <= adx2_r;
      ady3_r  <= ady2_r;
      msum3_r <= msum2_r;
      mb2_3_r <= mb2_2_r;
      vax3_r  <= vax2_r;
      vay3_r  <= vay2_r;
    end
  end

  // stage 4: signed dot product as magnitude and sign, squared distance
  logic             nx, ny, dneg_nxt;
  logic [DOT_W-1:0] dotm_nxt;
  logic [DOT_W-1:0] dotm_r, d2_r;
  logic [63:0]      rs2_4_r;
  logic             dneg_r, dxn4_r, dyn4_r, coin4_r;
  logic [MAG_W-1:0] adx4_r, ady4_r;
  logic [MUL_W-1:0] msum4_r, mb2_4_r;
  logic [31:0]      vax4_r, vay4_r;

  always_comb begin
    nx = nx0_3_r && (px_r != '0);
    ny = ny0_3_r && (py_r != '0);
    priority if (nx == ny) begin
      dotm_nxt = DOT_W'(px_r) + DOT_W'(py_r);
      dneg_nxt = nx;
    end else if (px_r >= py_r) begin
      dotm_nxt = DOT_W'(px_r - py_r);
      dneg_nxt = nx;
    end else begin
      dotm_nxt = DOT_W'(py_r - px_r);
      dneg_nxt = ny;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dotm_r  <= dotm_nxt;
      dneg_r  <= dneg_nxt && (dotm_nxt != '0);
      d2_r    <= DOT_W'(ax2_r) + DOT_W'(ay2_r);
      rs2_4_r <= rs2_r;
      dxn4_r  <= dxn3_r;
      dyn4_r  <= dyn3_r;
      coin4_r <= coin3_r;
      adx4_r  <= adx3_r;
      ady4_r  <= ady3_r;
      msum4_r <= msum3_r;
      mb2_4_r <= mb2_3_r;
      vax4_r  <= vax3_r;
      vay4_r  <= vay3_r;
    end
  end

  // stage 5: collision test, partial products of base and denominator
  localparam int LO_W = 34;
  localparam int HI_W = DOT_W - LO_W;

  logic [LO_W+MUL_W-1:0] bl_r, dl_r;
  logic [HI_W+MUL_W-1:0] bh_r, dh_r;
  logic                  appr5_r, coll5_r, coin5_r, qnx5_r, qny5_r, use5_r;
  logic [MAG_W-1:0]      adx5_r, ady5_r;
  logic [31:0]           vax5_r, vay5_r;

  always_ff @(posedge clk) begin
    if (en) begin
      bl_r    <= (LO_W+MUL_W)'(dotm_r[LO_W-1:0]) * (LO_W+MUL_W)'(mb2_4_r);
      bh_r    <= (HI_W+MUL_W)'(dotm_r[DOT_W-1:LO_W]) * (HI_W+MUL_W)'(mb2_4_r);
      dl_r    <= (LO_W+MUL_W)'(d2_r[LO_W-1:0]) * (LO_W+MUL_W)'(msum4_r);
      dh_r    <= (HI_W+MUL_W)'(d2_r[DOT_W-1:LO_W]) * (HI_W+MUL_W)'(msum4_r);
      appr5_r <= dneg_r;
      coll5_r <= dneg_r && (DOT_W'(rs2_4_r) >= d2_r);
      coin5_r <= coin4_r;
      qnx5_r  <= dneg_r ^ dxn4_r;
      qny5_r  <= dneg_r ^ dyn4_r;
      use5_r  <= !coin4_r && (msum4_r != '0);
      adx5_r  <= adx4_r;
      ady5_r  <= ady4_r;
      vax5_r  <= vax4_r;
      vay5_r  <= vay4_r;
    end
  end

  // stage 6: base and denominator
  logic [BAS_W-1:0] base_r, den_r;
  logic             appr6_r, coll6_r, coin6_r, qnx6_r, qny6_r, use6_r;
  logic [MAG_W-1:0] adx6_r, ady6_r;
  logic [31:0]      vax6_r, vay6_r;

  always_ff @(posedge clk) begin
    if (en) begin
      base_r  <= (BAS_W'(bh_r) << LO_W) + BAS_W'(bl_r);
      den_r   <= (BAS_W'(dh_r) << LO_W) + BAS_W'(dl_r);
      appr6_r <= appr5_r;
      coll6_r <= coll5_r;
      coin6_r <= coin5_r;
      qnx6_r  <= qnx5_r;
      qny6_r  <= qny5_r;
      use6_r  <= use5_r;
      adx6_r  <= adx5_r;
      ady6_r  <= ady5_r;
      vax6_r  <= vax5_r;
      vay6_r  <= vay5_r;
    end
  end

  // stage 7: dividend partial products, base cut in three slices
  localparam int SL_W = 28;
  localparam int PP_W = SL_W + MAG_W;

  logic [PP_W-1:0]  px0_r, px1_r, px2_r, py0_r, py1_r, py2_r;
  logic [BAS_W-1:0] den7_r;
  logic             appr7_r, coll7_r, coin7_r, qnx7_r, qny7_r, use7_r;
  logic [31:0]      vax7_r, vay7_r;

  always_ff @(posedge clk) begin
    if (en) begin
      px0_r   <= PP_W'(base_r[SL_W-1:0]) * PP_W'(adx6_r);
      px1_r   <= PP_W'(base_r[2*SL_W-1:SL_W]) * PP_W'(adx6_r);
      px2_r   <= PP_W'(base_r[BAS_W-1:2*SL_W]) * PP_W'(adx6_r);
      py0_r   <= PP_W'(base_r[SL_W-1:0]) * PP_W'(ady6_r);
      py1_r   <= PP_W'(base_r[2*SL_W-1:SL_W]) * PP_W'(ady6_r);
      py2_r   <= PP_W'(base_r[BAS_W-1:2*SL_W]) * PP_W'(ady6_r);
      den7_r  <= den_r;
      appr7_r <= appr6_r;
      coll7_r <= coll6_r;
      coin7_r <= coin6_r;
      qnx7_r  <= qnx6_r;
      qny7_r  <= qny6_r;
      use7_r  <= use6_r;
      vax7_r  <= vax6_r;
      vay7_r  <= vay6_r;
    end
  end

  // stage 8: dividends, divider request
  logic [NUM_W-1:0] numx_r, numy_r;
  logic [BAS_W-1:0] den8_r;
  side_t            side8_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      side8_r.vld <= 1'b0;
    end else if (en) begin
      numx_r <= NUM_W'(px0_r) + (NUM_W'(px1_r) << SL_W) + (NUM_W'(px2_r) << (2*SL_W));
      numy_r <= NUM_W'(py0_r) + (NUM_W'(py1_r) << SL_W) + (NUM_W'(py2_r) << (2*SL_W));
      den8_r <= den7_r;
      side8_r.vld    <= vld_r[6];
      side8_r.va_x   <= vax7_r;
      side8_r.va_y   <= vay7_r;
      side8_r.appr   <= appr7_r;
      side8_r.coll   <= coll7_r;
      side8_r.coin   <= coin7_r;
      side8_r.use_q  <= use7_r;
      side8_r.qneg_x <= qnx7_r;
      side8_r.qneg_y <= qny7_r;
    end
  end

  div_req_t reqx, reqy;
  div_rsp_t rspx, rspy;

  assign reqx = '{vld: vld_r[7], num: numx_r, den: den8_r};
  assign reqy = '{vld: vld_r[7], num: numy_r, den: den8_r};

  ecr_div u_div_x (.clk(clk), .rst_n(rst_n), .en(en), .req(reqx), .rsp(rspx));
  ecr_div u_div_y (.clk(clk), .rst_n(rst_n), .en(en), .req(reqy), .rsp(rspy));

  // side data travels alongside the divider stages
  side_t side_r [0:DIV_LAT-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < DIV_LAT; k++) begin
        side_r[k].vld <= 1'b0;
      end
    end else if (en) begin
      side_r[0] <= side8_r;
      for (int k = 1; k < DIV_LAT; k++) begin
        side_r[k] <= side_r[k-1];
      end
    end
  end

  // output stage: apply correction and saturate
  function automatic logic [32:0] apply_q(input logic [31:0] va, input logic use_q,
                                          input logic qneg, input logic [QUO_W-1:0] q);
    logic [QUO_W+1:0] s;
    logic             hi, lo;
    s = {{(QUO_W-30){va[31]}}, va};
    if (use_q) begin
      s = qneg ? s + (QUO_W+2)'(q) : s - (QUO_W+2)'(q);
    end
    hi = !s[QUO_W+1] && (s[QUO_W:31] != '0);
    lo = s[QUO_W+1] && (s[QUO_W:31] != '1);
    priority if (hi) apply_q = {1'b1, 32'h7fff_ffff};
    else if (lo) apply_q = {1'b1, 32'h8000_0000};
    else apply_q = {1'b0, s[31:0]};
  endfunction

  side_t       side_last;
  logic [32:0] rx, ry;

  assign side_last = side_r[DIV_LAT-1];
  assign rx = apply_q(side_last.va_x, side_last.use_q, side_last.qneg_x, rspx.quo);
  assign ry = apply_q(side_last.va_y, side_last.use_q, side_last.qneg_y, rspy.quo);

  logic        appr_r, coll_r, coin_r, sat_r;
  logic [31:0] nvx_r, nvy_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= rspx.vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      appr_r <= side_last.appr;
      coll_r <= side_last.coll;
      coin_r <= side_last.coin;
      sat_r  <= rx[32] || ry[32];
      nvx_r  <= rx[31:0];
      nvy_r  <= ry[31:0];
    end
  end

  assign out_valid       = out_valid_r;
  assign out_approaching = appr_r;
  assign out_colliding   = coll_r;
  assign out_new_vel_x   = nvx_r;
  assign out_new_vel_y   = nvy_r;
  assign out_coincident  = coin_r;
  assign out_saturated   = sat_r;

  a_coll_appr: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_colliding |-> out_approaching)
    else $error("collision flagged without approach");

  a_coin_flags: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_coincident |-> !out_approaching && !out_saturated)
    else $error("coincident result carries approach or saturation");

  a_div_align: assert property (@(posedge clk) disable iff (!rst_n)
    rspx.vld == side_last.vld && rspy.vld == side_last.vld)
    else $error("divider and side pipeline out of step");

endmodule
